### rtl/bcma_pkg.sv
// Shared types and constants for the bar close moving average block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bcma_pkg;

   // Field widths fixed by the interface
   localparam int FIELD_W    = 32;
   localparam int CNT_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Defaults for the top level parameters
   localparam int WINDOW_MAX_DEF = 64;
   localparam int PRICE_BITS_DEF = 32;

   // Reset value of the window length register
   localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd20;

   // Register index, taken from csr_paddr[2]
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   // Result status codes, also used as the item kind
   typedef enum logic [STATUS_W-1:0] {
      ST_APPEND = 2'd0,
      ST_REVISE = 2'd1,
      ST_STALE  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_DROP_RD,
      S_DROP_SUB,
      S_APPEND,
      S_REV_RD,
      S_REV_WR,
      S_DIV_START,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_item;
      logic drop_sub;
      logic append;
      logic rd_newest;
      logic rev_write;
      logic div_start;
      logic finish;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      status_type kind;
      logic       need_drop;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/bcma_div.sv
// Restoring divider, one quotient bit per cycle, for the window sum by the bar count.
// Depends on bcma_pkg for the count width.
`timescale 1ns / 1ps
`default_nettype none

module bcma_div #(
   parameter int DIVIDEND_W = 39
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DIVIDEND_W-1:0]      dividend,
   input  wire logic [bcma_pkg::CNT_W-1:0] divisor,
   output logic                            done,
   output logic [DIVIDEND_W-1:0]           quotient
);
   import bcma_pkg::*;

   localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      dvs_ff, dvs_in;

   logic [CNT_W:0]        shifted;
   logic [CNT_W+1:0]      diff;
   logic                  fits;

   // Trial subtract of the divisor from the shifted remainder
   always_comb begin
      shifted = {rem_ff, q_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~diff[CNT_W+1];
   end

   // Load on start, then shift in one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         q_in    = {q_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

### rtl/bcma_ctrl.sv
// Sequencer for the moving average: accept, drop oldest closes, append or revise,
// divide, deliver; a stale item goes straight to deliver. Depends on bcma_pkg for states, commands and status.
`timescale 1ns / 1ps
`default_nettype none

module bcma_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire bcma_pkg::dp_status_type status,
   output bcma_pkg::ctrl_cmd_type       cmd
);
   import bcma_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (status.kind)
               ST_APPEND: state_in = S_DROP_RD;
               ST_REVISE: state_in = S_REV_RD;
               default:   state_in = S_FINISH;
            endcase
         end
         S_DROP_RD: begin
            if (status.need_drop) state_in = S_DROP_SUB;
            else if (status.kind == ST_APPEND) state_in = S_APPEND;
            else state_in = S_DIV_START;
         end
         S_DROP_SUB:  state_in = S_DROP_RD;
         S_APPEND:    state_in = S_DIV_START;
         S_REV_RD:    state_in = S_REV_WR;
         S_REV_WR:    state_in = S_DROP_RD;
         S_DIV_START: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (status.div_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_DROP_SUB:  cmd.drop_sub  = 1'b1;
         S_APPEND:    cmd.append    = 1'b1;
         S_REV_RD:    cmd.rd_newest = 1'b1;
         S_REV_WR:    cmd.rev_write = 1'b1;
         S_DIV_START: cmd.div_start = 1'b1;
         S_FINISH:    cmd.finish    = status.out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/bcma_dp.sv
// Datapath: close ring memory, running sum, count, ring pointer, last bar time,
// divider and output register. Depends on bcma_pkg and bcma_div.
`timescale 1ns / 1ps
`default_nettype none

module bcma_dp #(
   parameter int WINDOW_MAX = 64,
   parameter int PRICE_W    = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bcma_pkg::ctrl_cmd_type        cmd,
   output bcma_pkg::dp_status_type            status,
   input  wire logic [bcma_pkg::CNT_W-1:0]    window_length,
   input  wire logic [bcma_pkg::FIELD_W-1:0]  req_bar_time,
   input  wire logic [bcma_pkg::FIELD_W-1:0]  req_close_price,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bcma_pkg::FIELD_W-1:0]       rsp_average,
   output logic [bcma_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bcma_pkg::CNT_W-1:0]         rsp_bars_counted
);
   import bcma_pkg::*;

   localparam int SUM_W  = PRICE_W + CNT_W;
   localparam int RING_W = $clog2(WINDOW_MAX);
   localparam int AW     = RING_W + 1;
   localparam int CMP_W  = ($clog2(WINDOW_MAX + 1) > CNT_W) ? $clog2(WINDOW_MAX + 1) : CNT_W;

   // Close ring
   logic [PRICE_W-1:0] close_window_ff [WINDOW_MAX];
   logic [PRICE_W-1:0] rd_data_ff;

   // Item and running state
   logic [FIELD_W-1:0] time_ff;
   logic [PRICE_W-1:0] price_ff;
   status_type         kind_ff, kind_in;
   logic               have_bar_ff;
   logic [FIELD_W-1:0] last_time_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [RING_W-1:0]  ring_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [FIELD_W-1:0] last_avg_ff;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_average_ff;
   status_type          rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic [CMP_W-1:0]    wl_ext;
   logic [CNT_W-1:0]    win;
   logic [CNT_W-1:0]    limit;
   logic [AW-1:0]       oldest_raw;
   logic [RING_W-1:0]   oldest_addr;
   logic [RING_W-1:0]   newest_addr;
   logic [RING_W-1:0]   ring_next;
   logic [RING_W-1:0]   rd_addr;
   logic                div_done;
   logic [SUM_W-1:0]    quotient;
   logic [FIELD_W-1:0]  avg_val;

   // Clamp the window to 1..WINDOW_MAX
   always_comb begin
      wl_ext = CMP_W'(window_length);
      if (window_length == '0) win = CNT_W'(1);
      else if (wl_ext > CMP_W'(WINDOW_MAX)) win = CNT_W'(WINDOW_MAX);
      else win = window_length;
      limit = (kind_ff == ST_APPEND) ? win - 1'b1 : win;
   end

   // Ring addresses, wrapping at WINDOW_MAX
   always_comb begin
      oldest_raw  = AW'(ring_ff) + AW'(WINDOW_MAX) - AW'(count_ff);
      oldest_addr = (oldest_raw >= AW'(WINDOW_MAX)) ? RING_W'(oldest_raw - AW'(WINDOW_MAX))
                                                     : RING_W'(oldest_raw);
      newest_addr = (ring_ff == '0) ? RING_W'(WINDOW_MAX - 1) : ring_ff - 1'b1;
      ring_next   = (ring_ff == RING_W'(WINDOW_MAX - 1)) ? '0 : ring_ff + 1'b1;
      rd_addr     = cmd.rd_newest ? newest_addr : oldest_addr;
   end

   // Classify the incoming item against the last stored bar
   always_comb begin
      if (!have_bar_ff || req_bar_time > last_time_ff) kind_in = ST_APPEND;
      else if (req_bar_time == last_time_ff) kind_in = ST_REVISE;
      else kind_in = ST_STALE;
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         close_window_ff[ring_ff] <= price_ff;
      end else if (cmd.rev_write) begin
         close_window_ff[newest_addr] <= price_ff;
      end
      rd_data_ff <= close_window_ff[rd_addr];
   end

   // Latch the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         time_ff  <= req_bar_time;
         price_ff <= req_close_price[PRICE_W-1:0];
         kind_ff  <= kind_in;
      end
   end

   // Running state: drop oldest, append, revise newest
   always_ff @(posedge clock) begin
      if (reset) begin
         have_bar_ff  <= 1'b0;
         last_time_ff <= '0;
         count_ff     <= '0;
         ring_ff      <= '0;
         sum_ff       <= '0;
         last_avg_ff  <= '0;
      end else begin
         if (cmd.drop_sub) begin
            sum_ff   <= sum_ff - SUM_W'(rd_data_ff);
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.append) begin
            sum_ff       <= sum_ff + SUM_W'(price_ff);
            count_ff     <= count_ff + 1'b1;
            ring_ff      <= ring_next;
            last_time_ff <= time_ff;
            have_bar_ff  <= 1'b1;
         end
         if (cmd.rev_write) begin
            sum_ff <= sum_ff - SUM_W'(rd_data_ff) + SUM_W'(price_ff);
         end
         if (cmd.finish) begin
            last_avg_ff <= avg_val;
         end
      end
   end

   bcma_div #(
      .DIVIDEND_W(SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Stale items repeat the last average
   assign avg_val = (kind_ff == ST_STALE) ? last_avg_ff : FIELD_W'(quotient);

   // Output register, free once the held item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_average_ff <= avg_val;
         rsp_status_ff  <= kind_ff;
         rsp_count_ff   <= count_ff;
      end
   end

   always_comb begin
      status.kind      = kind_ff;
      status.need_drop = count_ff > limit;
      status.div_done  = div_done;
      status.out_free  = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bars_counted = rsp_count_ff;

endmodule

`default_nettype wire

### rtl/bar_close_moving_average.sv
// Top level of the bar close moving average: window length register, controller
// and datapath. Depends on bcma_pkg, bcma_ctrl, bcma_dp.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    bar_time, close_price
//   rsp      out        rsp_valid/ready    average, status, bars_counted
//   csr      in/out     APB, pready high   window_length at byte address 0
//
// An appended bar drops oldest closes while the window is full, then enters the ring; a
// revised bar rewrites the newest close. The serial divider then divides the sum by the
// count, and a stale bar repeats the last average. The next item is accepted once the
// previous one reaches the output register, which holds its item while rsp_ready is low.
// Reset is synchronous and clears all control state; the ring needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module bar_close_moving_average #(
   parameter int WINDOW_MAX = bcma_pkg::WINDOW_MAX_DEF,
   parameter int PRICE_BITS = bcma_pkg::PRICE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bcma_pkg::FIELD_W-1:0]      req_bar_time,
   input  wire logic [bcma_pkg::FIELD_W-1:0]      req_close_price,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bcma_pkg::FIELD_W-1:0]           rsp_average,
   output logic [bcma_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bcma_pkg::CNT_W-1:0]             rsp_bars_counted,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bcma_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bcma_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bcma_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import bcma_pkg::*;

   localparam int PRICE_W = (PRICE_BITS < FIELD_W) ? PRICE_BITS : FIELD_W;

   logic [CNT_W-1:0] window_length_ff, window_length_in;
   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic             reg_sel;

   // Register file: a single window length register
   assign reg_sel    = (csr_paddr[2] == REG_WINDOW_LENGTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(window_length_ff) : '0;

   always_comb begin
      window_length_in = window_length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         window_length_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   bcma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcma_dp #(
      .WINDOW_MAX (WINDOW_MAX),
      .PRICE_W    (PRICE_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .window_length    (window_length_ff),
      .req_bar_time     (req_bar_time),
      .req_close_price  (req_close_price),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_status       (rsp_status),
      .rsp_bars_counted (rsp_bars_counted)
   );

endmodule

`default_nettype wire
